### hw/rtl/chs_pkg.sv
// Shared types and constants for the compass heading CORDIC pipeline.
`timescale 1ns / 1ps

package chs_pkg;

  localparam int IN_W      = 16;
  localparam int VEC_SHIFT = 24;
  localparam int VEC_W     = 42;   // |v| < 2^17 after gain, plus 24 fraction bits
  localparam int ANG_FRAC  = 20;
  localparam int ANG_W     = 30;   // degrees * 2^20, signed, covers -100 .. 360
  localparam int TABLE_LEN = 24;
  localparam int OUT_W     = 16;

  // atan(2^-i) in degrees * 2^20, rounded to nearest
  localparam int ATAN_TAB [TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658,   469357,   234682,   117342,  58671,   29335,
    14668,    7334,     3667,     1833,    917,     458,
    229,      115,      57,       29,      14,      7
  };

  localparam logic signed [ANG_W-1:0] DEG_0   = '0;
  localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90  * (2 ** ANG_FRAC));
  localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * (2 ** ANG_FRAC));
  localparam logic signed [ANG_W-1:0] DEG_270 = ANG_W'(270 * (2 ** ANG_FRAC));
  localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * (2 ** ANG_FRAC));

  // Data carried from cell to cell
  typedef struct packed {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [ANG_W-1:0] z;
    logic                    skip;  // axis case: angle already exact
  } chs_vec_t;

endpackage

### hw/rtl/chs_cell.sv
// One vectoring CORDIC iteration with its own pipeline register.
`timescale 1ns / 1ps

module chs_cell
  import chs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  chs_vec_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output chs_vec_t out_data
);

  localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(ATAN_TAB[STEP]);

  chs_vec_t data_next;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;

  assign in_ready = !out_valid || out_ready;

  // arithmetic shift gives floor on negatives
  assign dx = in_data.vy >>> STEP;
  assign dy = in_data.vx >>> STEP;

  always_comb begin
    data_next = in_data;
    if (!in_data.skip) begin
      if (!in_data.vy[VEC_W-1]) begin
        data_next.vx = in_data.vx + dx;
        data_next.vy = in_data.vy - dy;
        data_next.z  = in_data.z + ATAN;
      end else begin
        data_next.vx = in_data.vx - dx;
        data_next.vy = in_data.vy + dy;
        data_next.z  = in_data.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### hw/rtl/chs_post.sv
// Final cell: wrap negative angles, round to the output format, fold 360 onto 0, output register.
`timescale 1ns / 1ps

module chs_post
  import chs_pkg::*;
#(
  parameter int FRAC = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  chs_vec_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] heading
);

  localparam int SH = ANG_FRAC - FRAC;
  localparam logic [ANG_W-1:0] HALF = ANG_W'(2 ** (SH - 1));
  localparam logic [ANG_W-1:0] FULL = ANG_W'(360 * (2 ** FRAC));

  logic signed [ANG_W-1:0] z_wrap;
  logic        [ANG_W-1:0] rounded;
  logic        [ANG_W-1:0] folded;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    z_wrap  = in_data.z[ANG_W-1] ? in_data.z + DEG_360 : in_data.z;
    rounded = (ANG_W'(z_wrap) + HALF) >> SH;
    folded  = (rounded >= FULL) ? rounded - FULL : rounded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      heading <= folded[OUT_W-1:0];
    end
  end

endmodule

### hw/rtl/compass_heading_atan2_top.sv
// Top level: pipelined CORDIC compass heading from a magnetometer sample pair.
`timescale 1ns / 1ps
//
// Input stream (s_axis): one transfer carries a signed x/y field sample pair.
// Output stream (m_axis): one transfer per input, the heading atan2(y, x) in
// degrees, 0 up to below 360, unsigned with HEADING_FRAC_BITS fraction bits.
//
// The datapath is a row of CORDIC cells, one per iteration, each with its own
// register, followed by a rounding cell that is also the output register.
// Throughput: one pair per cycle while m_axis_tready stays high, set by the
// one-iteration-per-cell chain.
//
// Each cell has its own valid bit and takes new data when it is empty or its
// successor takes its contents, so bubbles close up and the block keeps
// accepting while a result waits on m_axis. If the receiver holds off, the
// pipeline fills and s_axis_tready then drops.
// Axis samples (x or y zero) bypass the iterations and give exact angles.
// Reset (rst, synchronous) clears all valid bits; no other state is kept.
//
module compass_heading_atan2_top
  import chs_pkg::*;
#(
  parameter int CORDIC_STEPS      = 16,
  parameter int HEADING_FRAC_BITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] field_x, [31:16] field_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] heading_deg
);

  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic signed [IN_W-1:0] field_x;
  logic signed [IN_W-1:0] field_y;
  logic signed [VEC_W-1:0] vx_in;
  logic signed [VEC_W-1:0] vy_in;
  logic x_zero;
  logic y_zero;

  chs_vec_t          stage_data  [NSTEPS+1];
  logic [NSTEPS:0]   stage_valid;
  logic [NSTEPS:0]   stage_ready;

  assign field_x = s_axis_tdata[15:0];
  assign field_y = s_axis_tdata[31:16];

  assign vx_in = {{(VEC_W - IN_W - VEC_SHIFT){field_x[IN_W-1]}}, field_x, {VEC_SHIFT{1'b0}}};
  assign vy_in = {{(VEC_W - IN_W - VEC_SHIFT){field_y[IN_W-1]}}, field_y, {VEC_SHIFT{1'b0}}};
  assign x_zero = (field_x == '0);
  assign y_zero = (field_y == '0);

  // Entry: fold the left half plane onto the right, seed the angle
  always_comb begin
    stage_data[0].skip = x_zero || y_zero;
    if (field_x[IN_W-1]) begin
      stage_data[0].vx = -vx_in;
      stage_data[0].vy = -vy_in;
      stage_data[0].z  = DEG_180;
    end else begin
      stage_data[0].vx = vx_in;
      stage_data[0].vy = vy_in;
      stage_data[0].z  = DEG_0;
    end
    if (x_zero && !y_zero) begin
      stage_data[0].z = field_y[IN_W-1] ? DEG_270 : DEG_90;
    end
  end

  assign stage_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = stage_ready[0];

  for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
    chs_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  chs_post #(
    .FRAC (HEADING_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[NSTEPS]),
    .in_ready  (stage_ready[NSTEPS]),
    .in_data   (stage_data[NSTEPS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .heading   (m_axis_tdata)
  );

endmodule

### dv/compass_heading_atan2_top_test.sv
// Stream testbench for the compass heading CORDIC: directed table, then random pairs.
`timescale 1ns / 1ps

module compass_heading_atan2_top_test
  import chs_pkg::*;
();

  localparam int STEPS        = 16;
  localparam int FRAC         = 7;
  localparam int RANDOM_PAIRS = 950;
  localparam int TAIL_PAIRS   = 100;   // last pairs go through with no idling
  localparam int DRAIN_CYCLES = 60;    // well past the pipeline latency
  localparam int WATCHDOG     = 2000;  // cycles with no transfer on either side

  localparam logic [15:0] HDG_0   = 16'd0;
  localparam logic [15:0] HDG_90  = 16'(90 << FRAC);
  localparam logic [15:0] HDG_180 = 16'(180 << FRAC);
  localparam logic [15:0] HDG_270 = 16'(270 << FRAC);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               known;    // heading typed in below, else predicted
    logic        [15:0] heading;
  } pair_row_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] heading;
  } pair_t;

  localparam int N_CASES = 22;

  // Directed part: axis samples, extremes, both half planes, wrap at 360
  pair_row_t heading_cases [N_CASES] = '{
    '{16'sd0,      16'sd0,      1'b1, HDG_0},    // zero vector
    '{16'sd1,      16'sd0,      1'b1, HDG_0},
    '{16'sd32767,  16'sd0,      1'b1, HDG_0},
    '{-16'sd1,     16'sd0,      1'b1, HDG_180},
    '{-16'sd32768, 16'sd0,      1'b1, HDG_180},
    '{16'sd0,      16'sd1,      1'b1, HDG_90},
    '{16'sd0,      16'sd32767,  1'b1, HDG_90},
    '{16'sd0,      -16'sd1,     1'b1, HDG_270},
    '{16'sd0,      -16'sd32768, 1'b1, HDG_270},
    '{16'sd32767,  16'sd32767,  1'b0, HDG_0},
    '{-16'sd32768, -16'sd32768, 1'b0, HDG_0},
    '{-16'sd32768, 16'sd32767,  1'b0, HDG_0},
    '{16'sd32767,  -16'sd32768, 1'b0, HDG_0},
    '{16'sd1,      16'sd1,      1'b0, HDG_0},
    '{-16'sd1,     16'sd1,      1'b0, HDG_0},
    '{-16'sd1,     -16'sd1,     1'b0, HDG_0},
    '{16'sd1,      -16'sd1,     1'b0, HDG_0},
    '{-16'sd32768, 16'sd1,      1'b0, HDG_0},    // just under 180
    '{-16'sd32768, -16'sd1,     1'b0, HDG_0},    // just over 180
    '{16'sd32767,  -16'sd1,     1'b0, HDG_0},    // rounds up to 360, wraps
    '{16'sd32767,  16'sd1,      1'b0, HDG_0},
    '{16'sd1,      -16'sd32768, 1'b0, HDG_0}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] field_x, [31:16] field_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [15:0] heading_deg

  pair_t       pair_q [$];
  logic [15:0] heading_q [$];
  logic [15:0] heading_on_bus;
  int          pairs_total;
  int          pairs_accepted = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          idle_cycles = 0;
  int          segment_cycles = 0;
  int          idle_odds = 0;       // 0: no idling in this segment
  bit          failed = 1'b0;

  compass_heading_atan2_top #(
    .CORDIC_STEPS      (STEPS),
    .HEADING_FRAC_BITS (FRAC)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Round the degree accumulator (20 fraction bits) half up, fold 360 onto 0
  function automatic logic [15:0] round_heading(input longint z);
    longint r;
    longint full;
    full = longint'(360) << FRAC;
    r = (z + (longint'(1) << (ANG_FRAC - FRAC - 1))) >>> (ANG_FRAC - FRAC);
    if (r >= full) r = r - full;
    return r[15:0];
  endfunction

  // Vectoring CORDIC on the sample pair, inputs scaled by 2^24
  function automatic logic [15:0] predict_heading(input logic signed [15:0] fx,
                                                   input logic signed [15:0] fy);
    longint vx;
    longint vy;
    longint z;
    longint dx;
    longint dy;
    int     n;
    if (fy == 0) return (fx < 0) ? round_heading(longint'(180) << ANG_FRAC) : HDG_0;
    if (fx == 0) return round_heading(longint'(fy > 0 ? 90 : 270) << ANG_FRAC);
    vx = longint'(fx) * (longint'(1) << VEC_SHIFT);
    vy = longint'(fy) * (longint'(1) << VEC_SHIFT);
    z  = 0;
    if (vx < 0) begin
      // left half plane: turn by 180 first
      vx = -vx;
      vy = -vy;
      z  = longint'(180) << ANG_FRAC;
    end
    n = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    for (int i = 0; i < n; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + longint'(ATAN_TAB[i]);
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = z + (longint'(360) << ANG_FRAC);
    return round_heading(z);
  endfunction

  // One random field: half uniform, with small, zero and extreme values mixed in
  function automatic logic signed [15:0] random_field();
    int          pick;
    logic [15:0] mag;
    pick = $urandom_range(0, 9);
    if (pick <= 4) return 16'($urandom());
    if (pick == 6) return 16'sd0;
    if (pick == 7) begin
      case ($urandom_range(0, 3))
        0: return 16'sd32767;
        1: return -16'sd32768;
        2: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    mag = (pick == 5) ? 16'($urandom_range(1, 15)) : 16'($urandom_range(1, 255));
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  // Stream driver, receiver and checker in one process so that a transfer on
  // each side and the expectation queue are handled in a fixed order
  always @(posedge clk) begin : stream_bfm
    bit          moved;
    bit          tail;
    logic [15:0] want;
    pair_t       p;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      tail  = (pair_q.size() < TAIL_PAIRS);

      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (heading_q.size() == 0) begin
          $error("heading_deg: transfer with nothing expected, actual %0d", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = heading_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("heading_deg: expected %0d, actual %0d", want, m_axis_tdata);
            failed = 1'b1;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        heading_q.push_back(heading_on_bus);
        pairs_accepted++;
      end

      // idling pattern changes from segment to segment; some segments run flat out
      if (segment_cycles == 0) begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 3;
          2: idle_odds = 7;
          default: idle_odds = 15;
        endcase
        segment_cycles = 128;
      end
      segment_cycles--;

      // sender: new pair only once the current one has gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pair_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!tail && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
          tx_gap = $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else begin
          p = pair_q.pop_front();
          s_axis_tdata   <= {p.y, p.x};
          heading_on_bus = p.heading;
          s_axis_tvalid  <= 1'b1;
        end
      end

      // receiver back-pressure bursts
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!tail && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        rx_gap = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end

      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("compass_heading_atan2_top test failed");
        $finish;
      end
    end
  end

  initial begin : run
    pair_t p;
    for (int i = 0; i < N_CASES; i++) begin
      p.x = heading_cases[i].x;
      p.y = heading_cases[i].y;
      p.heading = heading_cases[i].known ? heading_cases[i].heading
                                         : predict_heading(p.x, p.y);
      pair_q.push_back(p);
    end
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p.x = random_field();
      p.y = random_field();
      p.heading = predict_heading(p.x, p.y);
      pair_q.push_back(p);
    end
    pairs_total = pair_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pairs_accepted < pairs_total) @(posedge clk);
    while (heading_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("compass_heading_atan2_top test passed");
    end else begin
      $display("compass_heading_atan2_top test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/chs_pkg.sv
hw/rtl/chs_cell.sv
hw/rtl/chs_post.sv
hw/rtl/compass_heading_atan2_top.sv
dv/compass_heading_atan2_top_test.sv
